// ----- hdl/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scan core.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    // Widths of the register fields
    localparam int unsigned PAT_WORD_W   = 64;
    localparam int unsigned CARE_W       = 16;
    localparam int unsigned LEN_W        = 5;
    localparam int unsigned ADDR_W       = 64;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned BYTES_PER_WORD = PAT_WORD_W / 8;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ONLY = 3'd5;

    // Configuration register set
    typedef struct packed {
        logic [PAT_WORD_W-1:0] pat_low;
        logic [PAT_WORD_W-1:0] pat_high;
        logic [CARE_W-1:0]     care_mask;
        logic [LEN_W-1:0]      pat_length;
        logic [ADDR_W-1:0]     base_address;
        logic                  first_only;
    } cfg_t;

    // Pick pattern byte k out of the two packed pattern words
    function automatic logic [7:0] pat_byte(input logic [PAT_WORD_W-1:0] lo,
                                            input logic [PAT_WORD_W-1:0] hi,
                                            input logic [3:0] k);
        logic [PAT_WORD_W-1:0] word;
        word = k[3] ? hi : lo;
        return word[8*k[2:0] +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mbps_if.sv -----
// ----------------------------------------------------------------------------
// mbps_if
// Valid/ready channels of the scan core: byte requests in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;
    logic        done_res;

    modport source (output valid, output found, output match_address,
                    output done_res, input ready);
    modport sink   (input valid, input found, input match_address,
                    input done_res, output ready);
endinterface

`default_nettype wire

// ----- hdl/mbps_window_cmp.sv -----
// ----------------------------------------------------------------------------
// mbps_window_cmp
// Compares the newest pattern-length window bytes with the masked pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_window_cmp #(
    parameter int unsigned MAX_PATTERN_BYTES = 16
) (
    input  mbps_pkg::cfg_t cfg,
    input  logic [7:0]     win [MAX_PATTERN_BYTES],
    output logic           hit
);

    localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [MAX_PATTERN_BYTES-1:0] pos_ok;

    // Check each pattern position against the window byte it lines up with
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_pos
        logic [mbps_pkg::LEN_W-1:0] offs;
        logic [IDX_W-1:0]           idx;
        logic                       in_use;
        logic [7:0]                 win_byte;

        assign in_use = (mbps_pkg::LEN_W'(k) < cfg.pat_length);
        assign offs   = cfg.pat_length - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(k);
        assign idx    = offs[IDX_W-1:0];

        always_comb
        begin
            win_byte = 8'h00;
            if (in_use)
            begin
                win_byte = win[idx];
            end
        end

        assign pos_ok[k] = !in_use || !cfg.care_mask[k] ||
                           (win_byte == mbps_pkg::pat_byte(cfg.pat_low, cfg.pat_high,
                                                           4'(k)));
    end

    assign hit = &pos_ok;

endmodule

`default_nettype wire

// ----- hdl/masked_byte_pattern_scan_core.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_core
// Scans a byte stream for a masked pattern of up to 16 bytes and reports the
// start address of each match plus a done result on the region's last byte.
//
//   channel    dir  handshake      payload
//   byte_in    in   valid/ready    data_byte[7:0], last_byte
//   res_out    out  valid/ready    found, match_address[63:0], done_res
//   cfg        in   cfg_we         cfg_index[2:0], cfg_data[63:0]
//
// One byte per cycle sustained while no result is blocked at res_out; a
// result shows on res_out once its byte has passed the input register.
// The byte goes into an input register, the window compare and the address
// add sit between it and the result register.
// Reset clears the window, byte count, match flag, config and valid flags.
// A stalled result only holds back bytes that produce a result.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scan_core #(
    parameter int unsigned MAX_PATTERN_BYTES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    mbps_byte_if.sink                                byte_in,
    mbps_result_if.source                            res_out,
    input  wire logic                                cfg_we,
    input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mbps_pkg::cfg_t cfg_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Scan state
    logic [7:0]                 win_reg  [MAX_PATTERN_BYTES];
    logic [7:0]                 win_next [MAX_PATTERN_BYTES];
    logic [mbps_pkg::ADDR_W-1:0] seen_reg;
    logic [mbps_pkg::ADDR_W-1:0] seen_inc;
    logic                       matched_reg;

    // Result register
    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [mbps_pkg::ADDR_W-1:0] out_addr_reg;
    logic                        out_done_reg;

    logic hit;
    logic len_ok;
    logic seen_ok;
    logic found;
    logic has_result;
    logic out_free;
    logic advance;
    logic [mbps_pkg::ADDR_W-1:0] match_addr;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbps_pkg::REG_PAT_LOW:    cfg_reg.pat_low      <= cfg_data;
                mbps_pkg::REG_PAT_HIGH:   cfg_reg.pat_high     <= cfg_data;
                mbps_pkg::REG_CARE_MASK:  cfg_reg.care_mask    <= cfg_data[mbps_pkg::CARE_W-1:0];
                mbps_pkg::REG_PAT_LENGTH: cfg_reg.pat_length   <= cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::REG_BASE_ADDR:  cfg_reg.base_address <= cfg_data;
                mbps_pkg::REG_FIRST_ONLY: cfg_reg.first_only   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Shift the held byte into the window
    always_comb
    begin
        win_next[0] = in_byte_reg;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
    end

    mbps_window_cmp #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_cmp (
        .cfg (cfg_reg),
        .win (win_next),
        .hit (hit)
    );

    // Qualify the compare and form the start address
    assign seen_inc   = seen_reg + mbps_pkg::ADDR_W'(1);
    assign len_ok     = (cfg_reg.pat_length != '0) &&
                        (32'(cfg_reg.pat_length) <= MAX_PATTERN_BYTES);
    assign seen_ok    = (|seen_inc[mbps_pkg::ADDR_W-1:mbps_pkg::LEN_W]) ||
                        (seen_inc[mbps_pkg::LEN_W-1:0] >= cfg_reg.pat_length);
    assign found      = len_ok && seen_ok && !(cfg_reg.first_only && matched_reg) && hit;
    assign match_addr = cfg_reg.base_address + seen_inc
                        - mbps_pkg::ADDR_W'(cfg_reg.pat_length);
    assign has_result = found || in_last_reg;

    // Handshake: the held request moves on unless its result is blocked
    assign out_free      = !out_valid_reg || res_out.ready;
    assign advance       = in_valid_reg && (!has_result || out_free);
    assign byte_in.ready = !in_valid_reg || advance;

    // Hold the next request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            in_byte_reg <= byte_in.data_byte;
            in_last_reg <= byte_in.last_byte;
        end
    end

    // Advance the scan state; drop it all on the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                win_reg[i] <= 8'h00;
            end
            seen_reg    <= '0;
            matched_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                begin
                    win_reg[i] <= 8'h00;
                end
                seen_reg    <= '0;
                matched_reg <= 1'b0;
            end
            else
            begin
                win_reg     <= win_next;
                seen_reg    <= seen_inc;
                matched_reg <= matched_reg || found;
            end
        end
    end

    // Load or retire the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && has_result)
        begin
            out_found_reg <= found;
            out_addr_reg  <= found ? match_addr : '0;
            out_done_reg  <= in_last_reg;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.found         = out_found_reg;
    assign res_out.match_address = out_addr_reg;
    assign res_out.done_res      = out_done_reg;

    // A shown result always carries a match or a done mark
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> (res_out.found || res_out.done_res))
        else $error("result without match or done");

    // No address without a match
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && !res_out.found) |-> (res_out.match_address == '0))
        else $error("address set on a result without match");

    // The last byte clears the scan state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> ((seen_reg == '0) && !matched_reg))
        else $error("scan state not cleared after last byte");

    // In first-only mode, a second match in one scan is never reported
    a_first_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_reg.first_only && matched_reg) |-> !found)
        else $error("second match reported in first-only mode");

    // An empty input register always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> byte_in.ready)
        else $error("input register empty but not ready");

endmodule

`default_nettype wire
